// ===== design/hia_pkg.sv =====
// shared constants for the handle id allocator: field widths, operation and status codes
`default_nettype none
package hia_pkg;

  localparam int FUNC_W = 3;
  localparam int ID_W   = 31;
  localparam int SLOT_W = 11;
  localparam int STAT_W = 2;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam func_t FN_ALLOC  = 3'd0;
  localparam func_t FN_FREE   = 3'd1;
  localparam func_t FN_LOOKUP = 3'd2;
  localparam func_t FN_FIND   = 3'd3;
  localparam func_t FN_CLEAR  = 3'd4;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_BAD  = 2'd2;
  localparam status_t ST_NONE = 2'd3;

endpackage
`default_nettype wire

// ===== design/handle_id_allocator.sv =====
// handle id allocator: lifo free list of slots kept in one memory, walked by a small sequencer
//
// input channel (in_valid / in_stall) carries one command word: in_func selects
// allocate, free, lookup, find-next or clear; in_id is the id to free or look up,
// in_from_slot the first slot a find-next scan checks.
// result channel (out_valid / out_stall) returns one word per command: status,
// id and slot. cfg_wr_en / cfg_wr_data set the id offset, written while idle.
// steps per command, accept to result valid, set by the single read port of the
// link/allocated memory:
//   clear, id out of range, unused code, heap full, find-next from slot >= range: at accept
//   allocate from a non-empty list, free, lookup: one memory read, then allocate/free write
//   allocate that grows the list: one link write a cycle per new slot, a head read, the pop
//   find-next inside the range: a memory read, then one slot a cycle
// one command at a time: in_stall is high from accept until the command finishes.
// a finished result goes to the output register; if that still holds a stalled
// word the result waits in a holding register and in_stall stays high until it moves.
// reset (rst_n low, synchronous) empties the list, sets the range to zero and the
// offset to zero. no clearing pass: slots above the range are never read, and
// growth clears each new slot's allocated bit as it threads the link.
`default_nettype none
module handle_id_allocator
  import hia_pkg::*;
#(
  parameter int MAX_SLOTS = 1024,
  parameter int INCREMENT = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  // configuration
  input  wire               cfg_wr_en,
  input  wire  [ID_W-1:0]   cfg_wr_data,
  // command channel
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [FUNC_W-1:0] in_func,
  input  wire  [ID_W-1:0]   in_id,
  input  wire  [SLOT_W-1:0] in_from_slot,
  // result channel
  output logic              out_valid,
  input  wire               out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [ID_W-1:0]   out_result_id,
  output logic [SLOT_W-1:0] out_result_slot
);

  // count width holds MAX_SLOTS itself (empty-list marker), index width addresses the memory
  localparam int CW   = $clog2(MAX_SLOTS + 1);
  localparam int IW   = $clog2(MAX_SLOTS);
  localparam int SUMW = $clog2(MAX_SLOTS + INCREMENT + 1);
  localparam logic [CW-1:0] EMPTY = CW'(MAX_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GROW  = 3'd1;
  localparam logic [2:0] S_AREAD = 3'd2;
  localparam logic [2:0] S_AUPD  = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // memory word: {allocated, next-free link}
  logic [CW:0] mem [MAX_SLOTS];
  logic [CW:0] mem_q_r;

  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   range_r, range_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic [CW-1:0]   top_r, top_nxt;
  logic [IW-1:0]   slot_r, slot_nxt;
  func_t           func_r, func_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [ID_W-1:0] offset_r;

  // holding register for a result that finds the output still occupied
  status_t           res_status_r;
  logic [ID_W-1:0]   res_id_r;
  logic [SLOT_W-1:0] res_slot_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic [SLOT_W-1:0] out_slot_r;

  logic              rd_en, wr_en;
  logic [IW-1:0]     rd_addr, wr_addr;
  logic [CW:0]       wr_data;

  logic              fin;
  status_t           fin_status;
  logic [ID_W-1:0]   fin_id;
  logic [SLOT_W-1:0] fin_slot;

  logic              out_free;
  logic              q_alloc;
  logic [CW-1:0]     q_link;
  logic [ID_W-1:0]   id_diff;
  logic              id_in_range;
  logic              from_in_range;
  logic [SUMW-1:0]   grow_sum;
  logic [CW-1:0]     grow_top;
  logic [CW-1:0]     ptr_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  assign q_alloc = mem_q_r[CW];
  assign q_link  = mem_q_r[CW-1:0];

  // id to slot, wrapping in 31 bits
  assign id_diff       = in_id - offset_r;
  assign id_in_range   = id_diff < ID_W'(range_r);
  assign from_in_range = 32'(in_from_slot) < 32'(range_r);

  // growth stops at MAX_SLOTS
  assign grow_sum = SUMW'(range_r) + SUMW'(INCREMENT);
  assign grow_top = (grow_sum > SUMW'(MAX_SLOTS)) ? EMPTY : CW'(grow_sum);

  assign ptr_inc = ptr_r + CW'(1);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    range_nxt  = range_r;
    ptr_nxt    = ptr_r;
    top_nxt    = top_r;
    slot_nxt   = slot_r;
    func_nxt   = func_r;
    id_nxt     = id_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_id     = '0;
    fin_slot   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          id_nxt   = in_id;
          slot_nxt = id_diff[IW-1:0];
          case (in_func) inside
            FN_ALLOC: begin
              if (head_r != EMPTY) begin
                rd_en     = 1'b1;
                rd_addr   = head_r[IW-1:0];
                state_nxt = S_AUPD;
              end else if (range_r == EMPTY) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else begin
                ptr_nxt   = range_r;
                top_nxt   = grow_top;
                state_nxt = S_GROW;
              end
            end
            FN_FREE, FN_LOOKUP: begin
              if (id_in_range) begin
                rd_en     = 1'b1;
                rd_addr   = id_diff[IW-1:0];
                state_nxt = S_CHK;
              end else begin
                fin        = 1'b1;
                fin_status = ST_BAD;
              end
            end
            FN_FIND: begin
              if (from_in_range) begin
                rd_en     = 1'b1;
                rd_addr   = IW'(in_from_slot);
                ptr_nxt   = CW'(in_from_slot);
                state_nxt = S_SCAN;
              end else begin
                fin        = 1'b1;
                fin_status = ST_NONE;
                fin_slot   = in_from_slot;
              end
            end
            FN_CLEAR: begin
              range_nxt = '0;
              head_nxt  = EMPTY;
              fin       = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_GROW: begin
        // thread new slots in ascending order, last one ends the list
        wr_en   = 1'b1;
        wr_addr = ptr_r[IW-1:0];
        ptr_nxt = ptr_inc;
        if (ptr_inc == top_r) begin
          wr_data   = {1'b0, EMPTY};
          head_nxt  = range_r;
          range_nxt = top_r;
          state_nxt = S_AREAD;
        end else begin
          wr_data = {1'b0, ptr_inc};
        end
      end
      S_AREAD: begin
        rd_en     = 1'b1;
        rd_addr   = head_r[IW-1:0];
        state_nxt = S_AUPD;
      end
      S_AUPD: begin
        // pop the head, mark it allocated
        head_nxt = q_link;
        wr_en    = 1'b1;
        wr_addr  = head_r[IW-1:0];
        wr_data  = {1'b1, q_link};
        fin      = 1'b1;
        fin_id   = ID_W'(head_r) + offset_r;
        fin_slot = SLOT_W'(head_r);
      end
      S_CHK: begin
        fin = 1'b1;
        if (!q_alloc) begin
          fin_status = ST_BAD;
        end else if (func_r == FN_FREE) begin
          wr_en    = 1'b1;
          wr_addr  = slot_r;
          wr_data  = {1'b0, head_r};
          head_nxt = CW'(slot_r);
        end else begin
          fin_id   = id_r;
          fin_slot = SLOT_W'(slot_r);
        end
      end
      S_SCAN: begin
        // mem_q_r holds the word of ptr_r; fetch the next slot meanwhile
        if (q_alloc) begin
          fin      = 1'b1;
          fin_id   = ID_W'(ptr_r) + offset_r;
          fin_slot = SLOT_W'(ptr_r);
        end else if (ptr_inc == range_r) begin
          fin        = 1'b1;
          fin_status = ST_NONE;
          fin_slot   = SLOT_W'(range_r);
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_inc[IW-1:0];
          ptr_nxt = ptr_inc;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = out_free ? S_IDLE : S_DONE;
    end
  end

  // link / allocated memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= EMPTY;
      range_r     <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      range_r <= range_nxt;
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
      if (fin && out_free) begin
        out_valid_r <= 1'b1;
      end else if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    top_r  <= top_nxt;
    slot_r <= slot_nxt;
    func_r <= func_nxt;
    id_r   <= id_nxt;
    if (fin && out_free) begin
      out_status_r <= fin_status;
      out_id_r     <= fin_id;
      out_slot_r   <= fin_slot;
    end else if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_slot_r   <= res_slot_r;
    end
    if (fin && !out_free) begin
      res_status_r <= fin_status;
      res_id_r     <= fin_id;
      res_slot_r   <= fin_slot;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_id   = out_id_r;
  assign out_result_slot = out_slot_r;

  // free list head is either the empty marker or a slot inside the range
  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == EMPTY) || (head_r < range_r))
    else $error("free list head outside slot range");

  a_range_max: assert property (@(posedge clk) disable iff (!rst_n)
    range_r <= EMPTY)
    else $error("slot range beyond maximum");

  // a result waits in the holding register only while the output is occupied
  a_done_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> out_valid_r)
    else $error("holding state with empty output register");

  a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (ptr_r < range_r))
    else $error("scan pointer beyond range");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func == FN_CLEAR) |=> (range_r == '0 && head_r == EMPTY))
    else $error("clear did not empty the heap");

endmodule
`default_nettype wire
